[rtl/dle_pkg.sv]
package dle_pkg;

   // Framing control characters.
   localparam logic [7:0] DLE_CHAR = 8'h10;
   localparam logic [7:0] ETX_CHAR = 8'h03;

   // Verdict error codes.
   typedef enum logic [2:0] {
      ERR_OK    = 3'd0,
      ERR_START = 3'd1,
      ERR_STUFF = 3'd2,
      ERR_SUM   = 3'd3,
      ERR_TRAIL = 3'd4
   } err_type;

   // Result kinds carried on the response tuser bit.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // One result beat, before packing onto the response channel.
   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] frame_id;
      logic [7:0] frame_size;
      logic       frame_good;
      err_type    error_code;
      logic       send_ack;
      logic       send_nak;
      logic       last_result;
   } result_type;

endpackage

[rtl/dle_parse.sv]
module dle_parse import dle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       reply_enable,
   input  logic       take,
   input  logic [7:0] in_byte,
   input  logic       final_byte,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_START,
      PH_ID,
      PH_SIZE,
      PH_DATA,
      PH_SUM,
      PH_TDLE,
      PH_TETX,
      PH_DONE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       pending_ff, pending_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] size_ff, size_in;
   logic [7:0] taken_ff, taken_in;
   err_type    err_ff, err_in;

   logic       emit;
   logic       field_done;
   logic [7:0] sum_neg;
   err_type    verdict_err;

   assign sum_neg = 8'(8'd0 - sum_ff);

   // Per-byte parse step: unstuffing, field capture and checks.
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      sum_in     = sum_ff;
      id_in      = id_ff;
      size_in    = size_ff;
      taken_in   = taken_ff;
      err_in     = err_ff;
      emit       = 1'b0;
      field_done = 1'b0;

      if (err_ff == ERR_OK) begin
         unique case (phase_ff)
            PH_START: begin
               if (in_byte == DLE_CHAR) phase_in = PH_ID;
               else err_in = ERR_START;
            end
            PH_ID, PH_SIZE, PH_DATA, PH_SUM: begin
               if (pending_ff) begin
                  // Second copy of a doubled DLE.
                  pending_in = 1'b0;
                  if (in_byte != DLE_CHAR) err_in = ERR_STUFF;
                  else if (phase_ff == PH_SUM && sum_neg != DLE_CHAR) err_in = ERR_SUM;
                  else field_done = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_ID: begin
                        id_in  = in_byte;
                        sum_in = 8'(sum_ff + in_byte);
                     end
                     PH_SIZE: begin
                        size_in = in_byte;
                        sum_in  = 8'(sum_ff + in_byte);
                     end
                     PH_DATA: begin
                        emit     = 1'b1;
                        taken_in = 8'(taken_ff + 8'd1);
                        sum_in   = 8'(sum_ff + in_byte);
                     end
                     default: begin
                        if (in_byte != DLE_CHAR && sum_neg != in_byte) err_in = ERR_SUM;
                     end
                  endcase
                  if (!(phase_ff == PH_SUM && in_byte != DLE_CHAR && sum_neg != in_byte)) begin
                     if (in_byte == DLE_CHAR) pending_in = 1'b1;
                     else field_done = 1'b1;
                  end
               end
               // Advance once a field value is complete.
               if (field_done) begin
                  unique case (phase_ff)
                     PH_ID:   phase_in = PH_SIZE;
                     PH_SIZE: phase_in = (size_in == 8'd0) ? PH_SUM : PH_DATA;
                     PH_DATA: if (taken_in == size_in) phase_in = PH_SUM;
                     default: phase_in = PH_TDLE;
                  endcase
               end
            end
            PH_TDLE: begin
               if (in_byte == DLE_CHAR) phase_in = PH_TETX;
               else err_in = ERR_TRAIL;
            end
            PH_TETX: begin
               if (in_byte == ETX_CHAR) phase_in = PH_DONE;
               else err_in = ERR_TRAIL;
            end
            default: err_in = ERR_TRAIL;
         endcase
      end

      // The verdict treats an unfinished frame as a trailer error.
      verdict_err = err_in;
      if (err_in == ERR_OK && phase_in != PH_DONE) verdict_err = ERR_TRAIL;
   end

   // Result beat built from the same step.
   always_comb begin
      res           = '0;
      res_valid     = emit || final_byte;
      if (final_byte) begin
         res.kind        = KIND_VERDICT;
         res.frame_id    = id_in;
         res.frame_size  = size_in;
         res.frame_good  = (verdict_err == ERR_OK);
         res.error_code  = verdict_err;
         res.send_ack    = reply_enable && (verdict_err == ERR_OK);
         res.send_nak    = reply_enable && (verdict_err != ERR_OK);
         res.last_result = 1'b1;
      end else begin
         res.kind          = KIND_PAYLOAD;
         res.payload_byte  = in_byte;
         res.payload_index = taken_ff;
      end
   end

   // Frame state; the final byte returns it to its reset value.
   always_ff @(posedge clock) begin
      if (reset || (take && final_byte)) begin
         phase_ff   <= PH_START;
         pending_ff <= 1'b0;
         sum_ff     <= '0;
         id_ff      <= '0;
         size_ff    <= '0;
         taken_ff   <= '0;
         err_ff     <= ERR_OK;
      end else if (take) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         sum_ff     <= sum_in;
         id_ff      <= id_in;
         size_ff    <= size_in;
         taken_ff   <= taken_in;
         err_ff     <= err_in;
      end
   end

endmodule

[rtl/dle_out_buf.sv]
module dle_out_buf import dle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   output result_type out_data,
   input  logic       out_ready
);

   logic       main_valid_ff;
   logic       skid_valid_ff;
   result_type main_ff;
   result_type skid_ff;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Valid flags: the skid entry fills only while the main entry is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         main_valid_ff <= 1'b1;
         skid_valid_ff <= main_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         main_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push && !main_valid_ff) begin
         main_ff <= push_data;
      end
      if (push && main_valid_ff && !pop) begin
         skid_ff <= push_data;
      end
   end

endmodule

[rtl/dle_packet_deframer_unit.sv]
// Channel  Direction  Beat contents
// req_     in         tdata[7:0] in_byte, tlast final_byte
// rsp_     out        tdata: payload_byte, payload_index, frame_id, frame_size, frame_good,
//                     error_code, send_ack, send_nak; tuser kind; tlast last_result
// csr_     in         wdata reply_enable, written when wen is high
//
// One byte is parsed per cycle while req_tready is high, and each result is registered.
// The parse step is a single pass from the frame-state registers to the output register.
// A two-entry output buffer lets a new beat enter while a result waits; req_tready falls
// only when both entries hold results. Reset is synchronous and clears the frame state,
// the output buffer and reply_enable.
module dle_packet_deframer_unit import dle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_id, [31:24] frame_size,
   // [32] frame_good, [35:33] error_code, [36] send_ack, [37] send_nak, [39:38] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_wdata
);

   logic       reply_enable_ff;
   logic       take;
   logic       res_valid;
   logic       buf_full;
   result_type res;
   result_type out_res;

   assign req_tready = !buf_full;
   assign take       = req_tvalid && req_tready;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         reply_enable_ff <= 1'b0;
      end else if (csr_wen) begin
         reply_enable_ff <= csr_wdata;
      end
   end

   dle_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .reply_enable (reply_enable_ff),
      .take         (take),
      .in_byte      (req_tdata),
      .final_byte   (req_tlast),
      .res_valid    (res_valid),
      .res          (res)
   );

   dle_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take && res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_data  (out_res),
      .out_ready (rsp_tready)
   );

   // Pack the result beat.
   assign rsp_tdata = {2'b00, out_res.send_nak, out_res.send_ack, out_res.error_code,
                       out_res.frame_good, out_res.frame_size, out_res.frame_id,
                       out_res.payload_index, out_res.payload_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last_result;

`ifndef SYNTHESIS
   // A verdict always closes the frame and a payload beat never does.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("verdict kind and last flag disagree");

   // A good verdict carries no error code and never asks for a NAK.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && rsp_tdata[32]) |->
         (out_res.error_code == ERR_OK && !rsp_tdata[37]))
      else $error("good verdict with error or NAK");

   // Replies are never requested both ways at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[36] && rsp_tdata[37]))
      else $error("ACK and NAK both requested");

   // The buffer is full only after a push into a stalled output.
   assert property (@(posedge clock) disable iff (reset)
      $rose(buf_full) |-> $past(take && res_valid && rsp_tvalid && !rsp_tready))
      else $error("output buffer filled without a stalled push");
`endif

endmodule
